@@ sv/scip_pkg.sv @@
// Package for the sprite cell insert polar unit: constants, types and tables.
// No dependencies.
`timescale 1ns / 1ps
package scip_pkg;

  localparam int SlotCount = 64;
  localparam int SlotBits  = 6;
  localparam int CntBits   = 7;
  localparam int CoordBits = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;
  localparam int CordicSteps = 24;

  localparam logic [CfgIdxBits-1:0] CfgCellSize = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgPlayerX  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgPlayerY  = 2'd2;

  localparam logic [1:0] OutAdded = 2'd0;
  localparam logic [1:0] OutDup   = 2'd1;
  localparam logic [1:0] OutFull  = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StDiv, StScanRd, StScanCmp, StCentre, StSquare, StSqrt, StCordic, StDone
  } state_e;

  // Angle table, one turn is 2^32.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051D;
        5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2E;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
        5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
        5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/sprite_cell_insert_polar_unit.sv @@
// Top level of the sprite cell insert polar unit: config registers and sequencer.
// Depends on scip_pkg and scip_ctrl.
//
// Usage: pulse start_i with pos_x_i/pos_y_i while busy_o is low. The item
// is accepted at that edge. The block snaps the position to a grid cell,
// looks it up in a 64-entry cell table, appends it if new and room is left, and reports
// the cell centre, distance to the player and bearing.
// Sequence: the restoring division, then the table scan, which takes a RAM
// read and a compare per stored entry checked, then centre and squares, the
// bit-serial square root, the CORDIC, and posting the result; the scan alone
// varies in length. busy_o stays high until done_o rises, and a new
// transaction may be accepted in the cycle in which done_o is high.
// The result is shown for one cycle with done_o high; the receiver cannot
// stall it. Configuration writes via cfg_we_i, cfg_idx_i, cfg_data_i take
// effect at once and must happen only while idle.
// Reset empties the table and sets cell size 64, player at the origin.
`timescale 1ns / 1ps
module sprite_cell_insert_polar_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scip_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [scip_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             start_i,
  input  logic [15:0]                      pos_x_i,
  input  logic [15:0]                      pos_y_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [1:0]                       outcome_o,
  output logic [5:0]                       slot_o,
  output logic [16:0]                      centre_x_half_o,
  output logic [16:0]                      centre_y_half_o,
  output logic [24:0]                      distance_q8_o,
  output logic [15:0]                      bearing_o
);
  import scip_pkg::*;

  logic [10:0] cell_size_q;
  logic [15:0] player_x_q, player_y_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 11'd64; player_x_q <= '0; player_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCellSize: cell_size_q <= cfg_data_i[10:0];
        CfgPlayerX:  player_x_q <= cfg_data_i;
        CfgPlayerY:  player_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scip_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start_i & ~busy_o), .pos_x_i, .pos_y_i,
    .size_i(cell_size_q), .player_x_i(player_x_q), .player_y_i(player_y_q),
    .busy_o, .done_o, .outcome_o, .slot_o, .centre_x_half_o, .centre_y_half_o,
    .distance_q8_o, .bearing_o
  );
endmodule

@@ sv/scip_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module scip_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write when enabled; the read is registered and returns the old word on a write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ sv/scip_ctrl.sv @@
// Sequencer and shared datapath: division, table scan, square root, CORDIC.
// Depends on scip_pkg and scip_ram.
`timescale 1ns / 1ps
module scip_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [scip_pkg::CoordBits-1:0] pos_x_i,
  input  logic [scip_pkg::CoordBits-1:0] pos_y_i,
  input  logic [10:0]                   size_i,
  input  logic [15:0]                   player_x_i,
  input  logic [15:0]                   player_y_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [1:0]                    outcome_o,
  output logic [5:0]                    slot_o,
  output logic [16:0]                   centre_x_half_o,
  output logic [16:0]                   centre_y_half_o,
  output logic [24:0]                   distance_q8_o,
  output logic [15:0]                   bearing_o
);
  import scip_pkg::*;

  state_e state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [CntBits-1:0] count_q, count_d;
  logic [SlotBits:0] scan_q, scan_d;
  logic [10:0] size_q, size_d;
  // Restoring division of x and y together, one quotient bit per cycle.
  logic [15:0] qx_q, qx_d, qy_q, qy_d;
  logic [10:0] rx_q, rx_d, ry_q, ry_d;
  logic [1:0]  outc_q, outc_d;
  logic [5:0]  slot_q, slot_d;
  logic [16:0] cx_q, cx_d, cy_q, cy_d;
  // The full cell centre can pass 17 bits, so the differences need 19.
  logic signed [18:0] dx_q, dx_d, dy_q, dy_d;
  logic [35:0] sq_q, sq_d;
  logic [49:0] rad_q, rad_d;
  logic [25:0] root_q, root_d;
  logic [51:0] rem_q, rem_d;
  logic signed [31:0] cxr_q, cxr_d, cyr_q, cyr_d;
  logic [31:0] z_q, z_d;
  logic        done_q, done_d;
  logic        ram_we;
  logic [31:0] ram_wdata, ram_rdata;

  scip_ram #(.Width(32), .Depth(SlotCount)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(scan_q[SlotBits-1:0]),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic [11:0] tx, ty;
  logic [27:0] prod;
  logic [51:0] trial;
  logic signed [31:0] shx, shy;
  logic signed [18:0] sq_op;
  logic signed [37:0] sqp;
  assign tx = {rx_q, qx_q[15]};
  assign ty = {ry_q, qy_q[15]};
  assign ram_wdata = {qy_q, qx_q};
  assign shx = cxr_q >>> step_q;
  assign shy = cyr_q >>> step_q;
  assign trial = {rem_q[49:0], rad_q[49:48]} - {root_q, 2'b01};

  // One squarer, fed dx first and dy next.
  assign sq_op = (step_q == 5'd0) ? dx_q : dy_q;
  assign sqp = sq_op * sq_op;

  always_comb begin
    state_d = state_q; step_d = step_q; count_d = count_q; scan_d = scan_q;
    size_d = size_q; qx_d = qx_q; qy_d = qy_q; rx_d = rx_q; ry_d = ry_q;
    outc_d = outc_q; slot_d = slot_q; cx_d = cx_q; cy_d = cy_q;
    dx_d = dx_q; dy_d = dy_q; sq_d = sq_q; rad_d = rad_q; root_d = root_q;
    rem_d = rem_q; cxr_d = cxr_q; cyr_d = cyr_q; z_d = z_q; done_d = 1'b0;
    ram_we = 1'b0; prod = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          size_d = (size_i == 11'd0) ? 11'd1 : ((size_i > 11'd1024) ? 11'd1024 : size_i);
          qx_d = pos_x_i; qy_d = pos_y_i; rx_d = '0; ry_d = '0;
          step_d = '0; state_d = StDiv;
        end
      end
      StDiv: begin
        rx_d = (tx >= {1'b0, size_q}) ? 11'(tx - {1'b0, size_q}) : tx[10:0];
        ry_d = (ty >= {1'b0, size_q}) ? 11'(ty - {1'b0, size_q}) : ty[10:0];
        qx_d = {qx_q[14:0], tx >= {1'b0, size_q}};
        qy_d = {qy_q[14:0], ty >= {1'b0, size_q}};
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          scan_d = '0; state_d = StScanRd;
        end
      end
      StScanRd: begin
        // Address is presented; data returns next cycle.
        if (scan_q >= {1'b0, count_q[SlotBits-1:0]} && !count_q[SlotBits]) begin
          outc_d = OutAdded; slot_d = count_q[SlotBits-1:0];
          ram_we = 1'b1; count_d = count_q + 7'd1; state_d = StCentre;
        end else if (count_q[SlotBits] && scan_q[SlotBits]) begin
          outc_d = OutFull; slot_d = '0; state_d = StCentre;
        end else begin
          state_d = StScanCmp;
        end
      end
      StScanCmp: begin
        if (ram_rdata == {qy_q, qx_q}) begin
          outc_d = OutDup; slot_d = scan_q[SlotBits-1:0]; state_d = StCentre;
        end else begin
          scan_d = scan_q + 1'b1; state_d = StScanRd;
        end
      end
      StCentre: begin
        prod = {qx_q, 1'b1} * size_q;
        cx_d = prod[16:0];
        dx_d = $signed({1'b0, prod[17:0]}) - $signed({2'b00, player_x_i, 1'b0});
        prod = {qy_q, 1'b1} * size_q;
        cy_d = prod[16:0];
        dy_d = $signed({2'b00, player_y_i, 1'b0}) - $signed({1'b0, prod[17:0]});
        step_d = '0; sq_d = '0; state_d = StSquare;
      end
      StSquare: begin
        if (step_q == 5'd0) begin
          sq_d = sqp[35:0]; step_d = 5'd1;
        end else begin
          rad_d = {sq_q + sqp[35:0], 14'd0};
          root_d = '0; rem_d = '0; step_d = '0; state_d = StSqrt;
        end
      end
      StSqrt: begin
        // One result bit per cycle.
        if (!trial[51]) begin
          rem_d = trial; root_d = {root_q[24:0], 1'b1};
        end else begin
          rem_d = {rem_q[49:0], rad_q[49:48]}; root_d = {root_q[24:0], 1'b0};
        end
        rad_d = {rad_q[47:0], 2'b00};
        step_d = step_q + 5'd1;
        if (step_q == 5'd24) begin
          z_d = '0;
          cxr_d = 32'(dx_q) <<< 12; cyr_d = 32'(dy_q) <<< 12;
          if (dx_q < 0) begin
            cxr_d = -(32'(dx_q) <<< 12); cyr_d = -(32'(dy_q) <<< 12);
            z_d = 32'h80000000;
          end
          step_d = '0; state_d = StCordic;
        end
      end
      StCordic: begin
        if (cyr_q > 0) begin
          cxr_d = cxr_q + shy; cyr_d = cyr_q - shx; z_d = z_q + atan_turn(step_q);
        end else begin
          cxr_d = cxr_q - shy; cyr_d = cyr_q + shx; z_d = z_q - atan_turn(step_q);
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd23) begin
          if (dx_q == 0 && dy_q == 0) z_d = '0;
          state_d = StDone;
        end
      end
      StDone: begin
        done_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; done_q <= 1'b0; step_q <= '0; scan_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; done_q <= done_d;
      step_q <= step_d; scan_q <= scan_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    size_q <= size_d; qx_q <= qx_d; qy_q <= qy_d; rx_q <= rx_d; ry_q <= ry_d;
    outc_q <= outc_d; slot_q <= slot_d; cx_q <= cx_d; cy_q <= cy_d;
    dx_q <= dx_d; dy_q <= dy_d; sq_q <= sq_d; rad_q <= rad_d; root_q <= root_d;
    rem_q <= rem_d; cxr_q <= cxr_d; cyr_q <= cyr_d; z_q <= z_d;
  end

  logic [31:0] zr;
  assign zr = z_q + 32'h8000;
  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign outcome_o = outc_q;
  assign slot_o = slot_q;
  assign centre_x_half_o = cx_q;
  assign centre_y_half_o = cy_q;
  assign distance_q8_o = root_q[24:0];
  assign bearing_o = zr[31:16];
endmodule

@@ sv/scip_checker.sv @@
// Port-level checker for the sprite cell insert polar unit, with its bind.
// Depends on scip_pkg and sprite_cell_insert_polar_unit.
`timescale 1ns / 1ps
module scip_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [1:0] outcome_o,
  input logic [5:0] slot_o
);
  import scip_pkg::*;

  // An accepted transaction makes the block busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after start");
  // A result comes only while working or at its end.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("stray result");
  // Outcome code is legal.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (outcome_o != 2'd3)) else $error("bad outcome");
  // Full outcome reports slot zero.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && outcome_o == OutFull |-> slot_o == 6'd0) else $error("full slot");
endmodule

bind sprite_cell_insert_polar_unit scip_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .outcome_o, .slot_o
);

@@ tb/sprite_cell_insert_polar_unit_tb.sv @@
// Testbench for the sprite cell insert polar unit: directed and random transactions
// checked against a predictor of grid snap, cell table, distance and bearing.
// Depends on scip_pkg and sprite_cell_insert_polar_unit.
`timescale 1ns / 1ps
module sprite_cell_insert_polar_unit_tb;
  import scip_pkg::*;

  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [5:0]  slot;
    logic [16:0] cx_half;
    logic [16:0] cy_half;
    logic [24:0] dist_q8;
    logic [15:0] bearing;
  } cell_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        start_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  outcome_o;
  logic [5:0]  slot_o;
  logic [16:0] centre_x_half_o;
  logic [16:0] centre_y_half_o;
  logic [24:0] distance_q8_o;
  logic [15:0] bearing_o;

  // Predictor state: configuration copy and stored cell table.
  logic [10:0]  cell_size_q;
  logic [15:0]  player_x_q;
  logic [15:0]  player_y_q;
  logic [15:0]  table_col [SlotCount];
  logic [15:0]  table_row [SlotCount];
  int           table_fill;
  logic [31:0]  angle_step [CordicSteps];

  cell_report_t pending_reports [$];
  int           fail_count;
  longint       cycle_count;
  bit           idle_on;

  sprite_cell_insert_polar_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i,
    .pos_x_i, .pos_y_i, .busy_o, .done_o, .outcome_o, .slot_o,
    .centre_x_half_o, .centre_y_half_o, .distance_q8_o, .bearing_o
  );

  always #10 clk_i = ~clk_i;

  // Integer square root, one result bit per step.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC giving the angle of (dx, dy) as a 16-bit binary angle.
  function automatic logic [15:0] angle_of(input longint dx, input longint dy);
    longint x, y, nx, ny;
    logic [31:0] z;
    z = 32'h0;
    if (dx == 0 && dy == 0) return 16'h0;
    x = dx * 4096;
    y = dy * 4096;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + angle_step[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - angle_step[i];
      end
      x = nx;
      y = ny;
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  // Snap a position to its cell, update the table and build the report.
  function automatic cell_report_t snap_and_insert(input logic [15:0] px,
                                                   input logic [15:0] py);
    cell_report_t r;
    longint size, col, row, cxh, cyh, dx, dy;
    int hit;
    size = cell_size_q;
    hit = -1;
    if (size == 0) size = 1;
    if (size > 1024) size = 1024;
    col = px / size;
    row = py / size;
    for (int i = 0; i < table_fill; i++)
      if (hit < 0 && table_col[i] == col && table_row[i] == row) hit = i;
    if (hit >= 0) begin
      r.outcome = OutDup;
      r.slot = 6'(hit);
    end else if (table_fill >= SlotCount) begin
      r.outcome = OutFull;
      r.slot = '0;
    end else begin
      table_col[table_fill] = 16'(col);
      table_row[table_fill] = 16'(row);
      r.outcome = OutAdded;
      r.slot = 6'(table_fill);
      table_fill++;
    end
    cxh = 2 * size * col + size;
    cyh = 2 * size * row + size;
    dx = cxh - 2 * longint'(player_x_q);
    dy = 2 * longint'(player_y_q) - cyh;
    r.cx_half = cxh[16:0];
    r.cy_half = cyh[16:0];
    r.dist_q8 = 25'(root_floor(longint'(dx * dx + dy * dy) << 14));
    r.bearing = angle_of(dx, dy);
    return r;
  endfunction

  // Write one register while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgCellSize: cell_size_q = data[10:0];
      CfgPlayerX:  player_x_q = data;
      CfgPlayerY:  player_y_q = data;
      default: ;
    endcase
  endtask

  // Let every outstanding transaction finish before touching the registers.
  task automatic drain;
    start_i = 1'b0;
    while (pending_reports.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] size, input logic [15:0] px,
                            input logic [15:0] py);
    drain();
    write_reg(CfgCellSize, size);
    write_reg(CfgPlayerX, px);
    write_reg(CfgPlayerY, py);
  endtask

  // Send one position; start stays high until the next gap or the next item.
  // Busy is looked at on the falling edge, where it is stable, so the next
  // rising edge is the accepting one.
  task automatic send_pos(input logic [15:0] px, input logic [15:0] py);
    start_i = 1'b1;
    pos_x_i = px;
    pos_y_i = py;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_reports.push_back(snap_and_insert(px, py));
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      pos_x_i = 16'($urandom);
      pos_y_i = 16'($urandom);
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  // Position inside a random cell of a small window, so cells repeat often.
  function automatic logic [15:0] near_coord;
    int size;
    int v;
    size = cell_size_q;
    if (size == 0) size = 1;
    if (size > 1024) size = 1024;
    v = $urandom_range(0, 9) * size + $urandom_range(0, size - 1);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic test_defaults;
    send_pos(16'd0, 16'd0);
    send_pos(16'd63, 16'd63);
    send_pos(16'd0, 16'd0);
    send_pos(16'd64, 16'd0);
    send_pos(16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_size_extremes;
    // Zero cell size acts as one pixel.
    set_config(16'd0, 16'd0, 16'hFFFF);
    send_pos(16'd0, 16'hFFFF);
    send_pos(16'hFFFF, 16'd0);
    // Oversized cell acts as 1024; upper data bits are dropped.
    set_config(16'hFFFF, 16'hFFFF, 16'd0);
    send_pos(16'd1023, 16'd1023);
    send_pos(16'hFFFF, 16'h8000);
    set_config(16'd1024, 16'h8000, 16'h8000);
    send_pos(16'h8000, 16'h7FFF);
    set_config(16'd1, 16'd12345, 16'd54321);
    send_pos(16'd12345, 16'd54321);
  endtask

  task automatic test_at_player;
    // Size 2 puts the cell centre of pixels 100..101 on pixel 101.
    set_config(16'd2, 16'd101, 16'd201);
    send_pos(16'd100, 16'd200);
    send_pos(16'd101, 16'd201);
    send_pos(16'd103, 16'd201);
    send_pos(16'd101, 16'd199);
  endtask

  task automatic test_stale_cells;
    // Stored cells are compared as stored after a size change.
    set_config(16'd3, 16'd0, 16'd0);
    send_pos(16'd100, 16'd100);
    set_config(16'd5, 16'd0, 16'd0);
    send_pos(16'd165, 16'd165);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) send_pos(near_coord(), near_coord());
      else send_pos(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random_phases;
    set_config(16'd64, 16'd300, 16'd300);
    test_random(120);
    set_config(16'd1, 16'hFFFF, 16'hFFFF);
    test_random(120);
    set_config(16'hF800 | 16'd1024, 16'h8000, 16'd100);
    test_random(120);
    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    test_random(120);
    set_config(16'd0, 16'($urandom), 16'($urandom));
    test_random(120);
    idle_on = 1'b0;
    set_config(16'($urandom_range(1, 1024)), 16'($urandom), 16'($urandom));
    test_random(130);
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    cell_report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no transaction pending", $time);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (outcome_o !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome_o);
          fail_count++;
        end
        if (slot_o !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot_o);
          fail_count++;
        end
        if (centre_x_half_o !== want.cx_half) begin
          $display("%0t: centre_x_half expected %0d actual %0d", $time, want.cx_half,
                   centre_x_half_o);
          fail_count++;
        end
        if (centre_y_half_o !== want.cy_half) begin
          $display("%0t: centre_y_half expected %0d actual %0d", $time, want.cy_half,
                   centre_y_half_o);
          fail_count++;
        end
        if (distance_q8_o !== want.dist_q8) begin
          $display("%0t: distance_q8 expected %0d actual %0d", $time, want.dist_q8,
                   distance_q8_o);
          fail_count++;
        end
        if (bearing_o !== want.bearing) begin
          $display("%0t: bearing expected %0d actual %0d", $time, want.bearing, bearing_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sprite_cell_insert_polar_unit_tb failed");
      $finish;
    end
  end

  initial begin
    angle_step = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                   32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                   32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgCellSize;
    cfg_data_i = '0;
    start_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    table_fill = 0;
    cell_size_q = 11'd64;
    player_x_q = '0;
    player_y_q = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_defaults();
    test_size_extremes();
    test_at_player();
    test_stale_cells();
    test_random_phases();

    drain();
    repeat (250) @(negedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("sprite_cell_insert_polar_unit_tb passed");
    end else begin
      $display("sprite_cell_insert_polar_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/scip_pkg.sv
sv/scip_ram.sv
sv/scip_ctrl.sv
sv/sprite_cell_insert_polar_unit.sv
sv/scip_checker.sv
tb/sprite_cell_insert_polar_unit_tb.sv
